// ===== rtl/fls_pkg.sv =====
// Shared constants, types and tables for the falling streak animator.
package fls_pkg;

  localparam int unsigned MaxStreaksDef   = 8;
  localparam int unsigned PixelsPerStreak = 10;
  localparam int unsigned PaletteSize     = 7;
  localparam int unsigned FadeTaps        = 5;

  localparam int unsigned LenW     = 10;
  localparam int unsigned ColorW   = 24;
  localparam int unsigned PeriodW  = 20;
  localparam int unsigned AccW     = 40;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned PosW     = 13;
  localparam int unsigned PalW     = 3;
  localparam int unsigned TapW     = 3;
  localparam int unsigned ChanW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned ActW     = 2;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned DivCntW  = $clog2(LenW);

  // length / PixelsPerStreak as multiply and shift; exact for every 10-bit length
  localparam int unsigned PpsShift = 11;
  localparam int unsigned PpsRecip = ((1 << PpsShift) + PixelsPerStreak - 1) / PixelsPerStreak;

  localparam logic signed [PosW-1:0] WrapLimit = -13'sd5;

  typedef enum logic [ActW-1:0] {
    ActClear = 2'd0,
    ActSet   = 2'd1,
    ActShow  = 2'd2
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegBaseColor    = 2'd0,
    RegFramePeriod  = 2'd1,
    RegRotateColors = 2'd2,
    RegStripLength  = 2'd3
  } cfg_reg_e;

  // controller -> datapath
  typedef struct packed {
    logic    acc_add;
    logic    acc_clr;
    logic    pal_clr;
    logic    div_go;
    logic    count_load;
    logic    place_init;
    logic    place_step;
    logic    walk_init;
    logic    tap_step;
    logic    streak_move;
    logic    emit;
    action_e emit_act;
    logic    emit_last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic count_zero;
    logic idx_last;
    logic frame_due;
    logic pix_visible;
    logic tap_last;
    logic out_free;
  } dp_sts_t;

  // white, red, blue, green, yellow, magenta, cyan
  function automatic logic [ColorW-1:0] palette_color(input logic [PalW-1:0] idx);
    logic [ColorW-1:0] c;
    case (idx)
      3'd0:    c = 24'hFFFFFF;
      3'd1:    c = 24'hFF0000;
      3'd2:    c = 24'h0000FF;
      3'd3:    c = 24'h00FF00;
      3'd4:    c = 24'hFFFF00;
      3'd5:    c = 24'hFF00FF;
      3'd6:    c = 24'h00FFFF;
      default: c = 24'hFFFFFF;
    endcase
    return c;
  endfunction

  // Q1.8 fade, head pixel at full scale
  function automatic logic [8:0] fade_factor(input logic [TapW-1:0] tap);
    logic [8:0] f;
    case (tap)
      3'd0:    f = 9'd256;
      3'd1:    f = 9'd192;
      3'd2:    f = 9'd141;
      3'd3:    f = 9'd90;
      3'd4:    f = 9'd26;
      default: f = 9'd0;
    endcase
    return f;
  endfunction

  function automatic logic [ChanW-1:0] fade_channel(input logic [ChanW-1:0] c,
                                                    input logic [8:0] f);
    logic [16:0] p;
    p = 17'(c) * 17'(f);
    return p[15:8];
  endfunction

endpackage

// ===== rtl/falling_led_streak_animator_core.sv =====
// Top level of the falling LED streak animator.
//
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tuser: cmd; tdata: elapsed_time
// m_axis    out  tvalid/tready           tuser: action; tdata: index, g, r, b;
//                                        tlast: last
// cfg       in   cfg_valid/cfg_ready     cfg_index, cfg_data (always ready)
//
// Sequencing: one item at a time. A tick with no frame due only adds to the
// accumulator. A start runs one pass of the 10-step divider (length / streak
// count) unless no streak fits; the streak count itself comes from a reciprocal
// multiply. A frame walks five taps (head and four tail pixels) and one move per
// streak.
// Reset: rst_ni is asynchronous, active low; settings take their defaults,
// accumulator, streak count and palette index clear. Streak table is not reset.
// Stalls: results go through a single output register; the sequencer holds
// when a result is due while that register is full and not being taken. A new
// item is accepted while the final result of the previous one still waits.
module falling_led_streak_animator_core
  import fls_pkg::*;
#(
  parameter int unsigned MaxStreaks = MaxStreaksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input items
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic                s_axis_tuser_i,   // [0] cmd
  input  logic [TimeW-1:0]    s_axis_tdata_i,   // [31:0] elapsed_time
  // result items
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [ActW-1:0]     m_axis_tuser_o,   // [1:0] action
  // [9:0] pixel_index, [17:10] wire_byte0, [25:18] wire_byte1,
  // [33:26] wire_byte2, [39:34] zero
  output logic [OutDataW-1:0] m_axis_tdata_o,
  output logic                m_axis_tlast_o,   // last
  // settings
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // settings are taken at any time
  assign cfg_ready_o = 1'b1;

  fls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tuser_i  (s_axis_tuser_i),
    .s_tready_o (s_axis_tready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  fls_dp #(
    .MaxStreaks (MaxStreaks)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .elapsed_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tready_i  (m_axis_tready_i),
    .m_tuser_o   (m_axis_tuser_o),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tlast_o   (m_axis_tlast_o)
  );

endmodule

// ===== rtl/fls_div.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module fls_div
  import fls_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [LenW-1:0] dividend_i,
  input  logic [LenW-1:0] divisor_i,
  output logic            done_o,
  output logic [LenW-1:0] quotient_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [LenW-1:0]    rem_q, rem_d;
  logic [LenW-1:0]    quo_q, quo_d;
  logic [LenW-1:0]    dsr_q;
  logic [LenW:0]      rem_sh;
  logic               fits;

  always_comb begin
    rem_sh = {rem_q, quo_q[LenW-1]};
    fits   = rem_sh >= {1'b0, dsr_q};
    rem_d  = fits ? LenW'(rem_sh - {1'b0, dsr_q}) : rem_sh[LenW-1:0];
    quo_d  = {quo_q[LenW-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(LenW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/fls_ctrl.sv =====
// Sequencer for start, tick and frame rendering.
module fls_ctrl
  import fls_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    s_tvalid_i,
  input  logic    s_tuser_i,
  output logic    s_tready_o,
  output dp_cmd_t cmd_o,
  input  dp_sts_t sts_i
);

  typedef enum logic [3:0] {
    StIdle,
    StDivN,
    StDivGo,
    StDivS,
    StPlace,
    StCheck,
    StClear,
    StPixel,
    StMove,
    StShow
  } state_e;

  state_e state_q, state_d;
  logic   frame_q, frame_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    frame_d    = frame_q;
    s_tready_o = (state_q == StIdle);
    case (state_q)
      StIdle: begin
        if (s_tvalid_i) begin
          if (s_tuser_i) begin
            cmd_o.acc_add = 1'b1;
            state_d       = StCheck;
          end else begin
            cmd_o.acc_clr = 1'b1;
            cmd_o.pal_clr = 1'b1;
            frame_d       = 1'b0;
            state_d       = StDivN;
          end
        end
      end
      StDivN: begin
        cmd_o.count_load = 1'b1;
        state_d          = StDivGo;
      end
      StDivGo: begin
        if (sts_i.count_zero) begin
          state_d = StClear;
        end else begin
          cmd_o.div_go = 1'b1;
          state_d      = StDivS;
        end
      end
      StDivS: begin
        if (sts_i.div_done) begin
          cmd_o.place_init = 1'b1;
          state_d          = StPlace;
        end
      end
      StPlace: begin
        cmd_o.place_step = 1'b1;
        if (sts_i.idx_last) state_d = StClear;
      end
      StCheck: begin
        if (sts_i.frame_due) begin
          cmd_o.acc_clr   = 1'b1;
          cmd_o.walk_init = 1'b1;
          frame_d         = 1'b1;
          state_d         = StClear;
        end else begin
          state_d = StIdle;
        end
      end
      StClear: begin
        if (sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_act = ActClear;
          state_d        = (frame_q && !sts_i.count_zero) ? StPixel : StShow;
        end
      end
      StPixel: begin
        if (sts_i.pix_visible && sts_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.emit_act = ActSet;
        end
        if (!sts_i.pix_visible || sts_i.out_free) begin
          if (sts_i.tap_last) state_d = StMove;
          else                cmd_o.tap_step = 1'b1;
        end
      end
      StMove: begin
        cmd_o.streak_move = 1'b1;
        state_d           = sts_i.idx_last ? StShow : StPixel;
      end
      StShow: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_act  = ActShow;
          cmd_o.emit_last = 1'b1;
          state_d         = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      frame_q <= 1'b0;
    end else begin
      state_q <= state_d;
      frame_q <= frame_d;
    end
  end

`ifndef SYNTHESIS
  a_emit_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free)
    else $error("emit without a free output slot");
`endif

endmodule

// ===== rtl/fls_dp.sv =====
// Datapath: settings, accumulator, streak table, fades and output register.
module fls_dp
  import fls_pkg::*;
#(
  parameter int unsigned MaxStreaks = MaxStreaksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [TimeW-1:0]    elapsed_i,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [ActW-1:0]     m_tuser_o,
  output logic [OutDataW-1:0] m_tdata_o,
  output logic                m_tlast_o
);

  localparam int unsigned IdxW = (MaxStreaks > 1) ? $clog2(MaxStreaks) : 1;
  localparam int unsigned CntW = $clog2(MaxStreaks + 1);

  // settings
  logic [ColorW-1:0]  base_q;
  logic [PeriodW-1:0] period_q;
  logic               rotate_q;
  logic [LenW-1:0]    len_q;

  logic [AccW-1:0] acc_q;
  logic [CntW-1:0] cnt_q;
  logic [PalW-1:0] pal_q;
  logic [IdxW-1:0] idx_q;
  logic [TapW-1:0] tap_q;

  logic signed [PosW-1:0] pos_q [MaxStreaks];
  logic [ColorW-1:0]      col_q [MaxStreaks];
  logic [LenW-1:0]        spacing_q;
  logic [LenW:0]          place_pos_q;

  logic                   out_valid_q;
  action_e                out_act_q;
  logic                   out_last_q;
  logic [LenW-1:0]        out_idx_q;
  logic [ChanW-1:0]       out_g_q, out_r_q, out_b_q;

  logic [AccW:0]          acc_sum;
  logic [AccW-1:0]        acc_sat;
  logic [PalW-1:0]        pal_next;
  logic [LenW+7:0]        len_prod;
  logic [LenW-1:0]        len_div;
  logic [LenW-1:0]        div_dsr;
  logic [LenW-1:0]        quo;
  logic                   div_done;
  logic signed [PosW-1:0] cur_pos, pix_pos, dec_pos, len_s;
  logic [ColorW-1:0]      cur_col;
  logic [8:0]             fade;
  logic                   wrap;
  logic                   out_free;

  always_comb begin
    acc_sum  = {1'b0, acc_q} + (AccW + 1)'(elapsed_i);
    acc_sat  = acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
    pal_next = (pal_q == PalW'(PaletteSize - 1)) ? '0 : pal_q + PalW'(1);
    // streaks that fit: length / pixels per streak
    len_prod = (LenW + 8)'(len_q) * (LenW + 8)'(PpsRecip);
    len_div  = LenW'(len_prod >> PpsShift);
    div_dsr  = LenW'(cnt_q);
    len_s    = $signed(PosW'(len_q));
    cur_pos  = pos_q[idx_q];
    cur_col  = col_q[idx_q];
    pix_pos  = cur_pos + $signed(PosW'(tap_q));
    dec_pos  = cur_pos - PosW'(1);
    wrap     = dec_pos <= WrapLimit;
    fade     = fade_factor(tap_q);
    out_free = !out_valid_q || m_tready_i;

    sts_o.div_done    = div_done;
    sts_o.count_zero  = (cnt_q == '0);
    sts_o.idx_last    = (CntW'(idx_q) + CntW'(1)) == cnt_q;
    sts_o.frame_due   = acc_q > AccW'(period_q);
    sts_o.pix_visible = !pix_pos[PosW-1] && (pix_pos < len_s);
    sts_o.tap_last    = (tap_q == TapW'(FadeTaps - 1));
    sts_o.out_free    = out_free;
  end

  fls_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (len_q),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= 24'hFFFFFF;
      period_q    <= 20'd60000;
      rotate_q    <= 1'b1;
      len_q       <= 10'd60;
      acc_q       <= '0;
      cnt_q       <= '0;
      pal_q       <= '0;
      idx_q       <= '0;
      tap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegBaseColor:    base_q   <= cfg_data_i[ColorW-1:0];
          RegFramePeriod:  period_q <= cfg_data_i[PeriodW-1:0];
          RegRotateColors: rotate_q <= cfg_data_i[0];
          RegStripLength:  len_q    <= cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end

      if (cmd_i.acc_clr)      acc_q <= '0;
      else if (cmd_i.acc_add) acc_q <= acc_sat;

      if (cmd_i.count_load) begin
        cnt_q <= (len_div > LenW'(MaxStreaks)) ? CntW'(MaxStreaks) : CntW'(len_div);
      end

      if (cmd_i.pal_clr) begin
        pal_q <= '0;
      end else if (rotate_q && (cmd_i.place_step || (cmd_i.streak_move && wrap))) begin
        pal_q <= pal_next;
      end

      if (cmd_i.place_init || cmd_i.walk_init) begin
        idx_q <= '0;
        tap_q <= '0;
      end else if (cmd_i.place_step) begin
        idx_q <= idx_q + IdxW'(1);
      end else if (cmd_i.streak_move) begin
        idx_q <= idx_q + IdxW'(1);
        tap_q <= '0;
      end else if (cmd_i.tap_step) begin
        tap_q <= tap_q + TapW'(1);
      end

      if (cmd_i.emit)      out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.place_init) begin
      spacing_q   <= quo;
      place_pos_q <= (LenW + 1)'(len_q);
    end else if (cmd_i.place_step) begin
      place_pos_q <= place_pos_q + (LenW + 1)'(spacing_q);
    end

    if (cmd_i.place_step) begin
      pos_q[idx_q] <= $signed(PosW'(place_pos_q));
      col_q[idx_q] <= rotate_q ? palette_color(pal_q) : base_q;
    end else if (cmd_i.streak_move) begin
      pos_q[idx_q] <= wrap ? len_s : dec_pos;
      if (wrap && rotate_q) col_q[idx_q] <= palette_color(pal_q);
    end

    if (cmd_i.emit) begin
      out_act_q  <= cmd_i.emit_act;
      out_last_q <= cmd_i.emit_last;
      if (cmd_i.emit_act == ActSet) begin
        out_idx_q <= pix_pos[LenW-1:0];
        out_r_q   <= fade_channel(cur_col[23:16], fade);
        out_g_q   <= fade_channel(cur_col[15:8], fade);
        out_b_q   <= fade_channel(cur_col[7:0], fade);
      end else begin
        out_idx_q <= '0;
        out_r_q   <= '0;
        out_g_q   <= '0;
        out_b_q   <= '0;
      end
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_act_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {{(OutDataW - LenW - 3 * ChanW){1'b0}},
                       out_b_q, out_r_q, out_g_q, out_idx_q};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxStreaks))
    else $error("streak count above maximum");
  a_pal_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pal_q < PalW'(PaletteSize))
    else $error("palette index out of range");
  a_last_is_show: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> (out_act_q == ActShow))
    else $error("last flag on an item other than show");
  a_tap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_q < TapW'(FadeTaps))
    else $error("tail tap out of range");
`endif

endmodule

// ===== sim/fls_tb_pkg.sv =====
// Command codes shared by the streak animator testbench files.
package fls_tb_pkg;

  typedef enum logic {
    CmdStart = 1'b0,
    CmdTick  = 1'b1
  } cmd_e;

endpackage

// ===== sim/streak_frame_checker.sv =====
// Checker: predicts the animator's result items and compares them as they leave.
module streak_frame_checker
  import fls_pkg::*;
  import fls_tb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic                s_tuser_i,
  input  logic [TimeW-1:0]    s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [ActW-1:0]     m_tuser_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  input  logic                m_tlast_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         results_o,
  output int unsigned         frames_o,
  output int unsigned         widest_o
);

  localparam int              StreakSlots = MaxStreaksDef;
  localparam logic [AccW-1:0] AccCeiling  = '1;
  localparam int unsigned     ReportLimit = 10;

  typedef struct packed {
    action_e          act;
    logic [LenW-1:0]  idx;
    logic [ChanW-1:0] grn;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] blu;
    logic             last;
  } strip_op_t;

  logic [ColorW-1:0]      base_color;
  logic [PeriodW-1:0]     frame_period;
  logic                   rotate;
  logic [LenW-1:0]        strip_len;
  logic [AccW-1:0]        time_acc;
  logic signed [PosW-1:0] streak_pos [StreakSlots];
  logic [ColorW-1:0]      streak_rgb [StreakSlots];
  logic [3:0]             streak_cnt;
  logic [PalW-1:0]        hue_idx;
  strip_op_t              ops_due [$];
  int unsigned            fails   = 0;
  int unsigned            results = 0;
  int unsigned            frames  = 0;
  int unsigned            widest  = 0;

  // white, red, blue, green, yellow, magenta, cyan
  function automatic logic [ColorW-1:0] hue(input logic [PalW-1:0] i);
    case (i)
      3'd1:    return 24'hFF0000;
      3'd2:    return 24'h0000FF;
      3'd3:    return 24'h00FF00;
      3'd4:    return 24'hFFFF00;
      3'd5:    return 24'hFF00FF;
      3'd6:    return 24'h00FFFF;
      default: return 24'hFFFFFF;
    endcase
  endfunction

  // head at full scale, then four tail taps in Q1.8
  function automatic logic [8:0] tap_gain(input int tap);
    case (tap)
      0:       return 9'd256;
      1:       return 9'd192;
      2:       return 9'd141;
      3:       return 9'd90;
      default: return 9'd26;
    endcase
  endfunction

  function automatic logic [ChanW-1:0] dim(input logic [ChanW-1:0] c, input logic [8:0] g);
    int unsigned p;
    p = c * g;
    return ChanW'(p >> 8);
  endfunction

  task automatic next_hue(output logic [ColorW-1:0] c);
    c = hue(hue_idx);
    hue_idx = (hue_idx == PalW'(PaletteSize - 1)) ? '0 : hue_idx + 1'b1;
  endtask

  task automatic queue_op(input action_e a, input int idx, input logic [ColorW-1:0] c,
                          input logic last);
    strip_op_t op;
    op.act  = a;
    op.idx  = LenW'(idx);
    op.red  = c[23:16];
    op.grn  = c[15:8];
    op.blu  = c[7:0];
    op.last = last;
    ops_due.push_back(op);
  endtask

  task automatic advance_strip(input cmd_e cmd, input logic [TimeW-1:0] dt);
    int                n;
    int                gap;
    int                p;
    int                i;
    int                tap;
    int unsigned       emitted;
    logic [AccW:0]     sum;
    logic [ColorW-1:0] c;
    logic [8:0]        g;
    if (cmd == CmdStart) begin
      n = int'(strip_len) / PixelsPerStreak;
      if (n > StreakSlots) n = StreakSlots;
      gap = (n != 0) ? int'(strip_len) / n : 0;
      time_acc   = '0;
      hue_idx    = '0;
      streak_cnt = 4'(n);
      for (i = 0; i < n; i++) begin
        if (rotate) next_hue(c);
        else c = base_color;
        streak_rgb[i] = c;
        streak_pos[i] = PosW'(int'(strip_len) + i * gap);
      end
      queue_op(ActClear, 0, '0, 1'b0);
      queue_op(ActShow, 0, '0, 1'b1);
    end else begin
      sum = {1'b0, time_acc} + (AccW + 1)'(dt);
      time_acc = (sum > {1'b0, AccCeiling}) ? AccCeiling : sum[AccW-1:0];
      if (time_acc > AccW'(frame_period)) begin
        queue_op(ActClear, 0, '0, 1'b0);
        emitted = 2;
        for (i = 0; i < int'(streak_cnt) && i < StreakSlots; i++) begin
          for (tap = 0; tap < FadeTaps; tap++) begin
            p = int'(streak_pos[i]) + tap;
            if (p >= 0 && p < int'(strip_len)) begin
              c = streak_rgb[i];
              g = tap_gain(tap);
              queue_op(ActSet, p, {dim(c[23:16], g), dim(c[15:8], g), dim(c[7:0], g)}, 1'b0);
              emitted++;
            end
          end
          streak_pos[i] = streak_pos[i] - 13'sd1;
          // fell off the bottom: back to the top, next colour if rotating
          if (streak_pos[i] <= WrapLimit) begin
            streak_pos[i] = {3'b000, strip_len};
            if (rotate) begin
              next_hue(c);
              streak_rgb[i] = c;
            end
          end
        end
        queue_op(ActShow, 0, '0, 1'b1);
        time_acc = '0;
        frames++;
        if (emitted > widest) widest = emitted;
      end
    end
  endtask

  task automatic check_result(input logic [ActW-1:0] act, input logic [OutDataW-1:0] data,
                              input logic last);
    strip_op_t want;
    results++;
    if (ops_due.size() == 0) begin
      fails++;
      if (fails <= ReportLimit)
        $display("%0t: unexpected result item: act %0d data %h last %0b",
                 $realtime, act, data, last);
    end else begin
      want = ops_due.pop_front();
      if (act !== want.act || data[9:0] !== want.idx || data[17:10] !== want.grn ||
          data[25:18] !== want.red || data[33:26] !== want.blu || data[39:34] !== '0 ||
          last !== want.last) begin
        fails++;
        if (fails <= ReportLimit)
          $display("%0t: result item %0d wrong: want act %0d idx %0d g/r/b %h/%h/%h last %0b; %s",
                   $realtime, results, want.act, want.idx, want.grn, want.red, want.blu,
                   want.last, $sformatf("got act %0d idx %0d g/r/b %h/%h/%h pad %h last %0b",
                   act, data[9:0], data[17:10], data[25:18], data[33:26], data[39:34], last));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_color   = 24'hFFFFFF;
      frame_period = 20'd60000;
      rotate       = 1'b1;
      strip_len    = 10'd60;
      time_acc     = '0;
      streak_cnt   = '0;
      hue_idx      = '0;
      ops_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          RegBaseColor:    base_color   = cfg_data_i[ColorW-1:0];
          RegFramePeriod:  frame_period = cfg_data_i[PeriodW-1:0];
          RegRotateColors: rotate       = cfg_data_i[0];
          RegStripLength:  strip_len    = cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) advance_strip(cmd_e'(s_tuser_i), s_tdata_i);
      if (m_tvalid_i && m_tready_i) check_result(m_tuser_i, m_tdata_i, m_tlast_i);
    end
    fail_count_o <= fails;
    pending_o    <= ops_due.size();
    results_o    <= results;
    frames_o     <= frames;
    widest_o     <= widest;
  end

endmodule

// ===== sim/tb_falling_led_streak_animator_core.sv =====
// Testbench top: drives items and settings into the streak animator, gives the verdict.
module tb_falling_led_streak_animator_core;
  import fls_pkg::*;
  import fls_tb_pkg::*;

  localparam int unsigned HalfPeriod  = 4;
  localparam int unsigned ResetCycles = 7;
  localparam int unsigned QuietCycles = 80;        // lets a silent tick finish after the drain
  localparam int unsigned HoldCycles  = 400;       // long output hold, fills the block
  localparam int unsigned PhaseItems  = 20;
  localparam int unsigned CycleLimit  = 1_000_000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic                s_tuser   = 1'b0;
  logic [TimeW-1:0]    s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [ActW-1:0]     m_tuser;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tlast;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned hold_req     = 0;   // bumped by the stimulus to ask for a hold
  int unsigned hold_ack     = 0;
  int unsigned hold_left    = 0;
  int unsigned items_sent   = 0;
  int unsigned cycle_count  = 0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned frames_seen;
  int unsigned widest_frame;

  initial begin
    forever #HalfPeriod clk = ~clk;
  end

  falling_led_streak_animator_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  streak_frame_checker u_frame_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tuser_i    (s_tuser),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tuser_i    (m_tuser),
    .m_tdata_i    (m_tdata),
    .m_tlast_i    (m_tlast),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results_seen),
    .frames_o     (frames_seen),
    .widest_o     (widest_frame)
  );

  // Run limit: far above the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d result items still due", cycle_count, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold counted down here on request.
  always @(negedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready  <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Offer one item after a random gap; returns at the accepting edge.
  task automatic send_item(input cmd_e cmd, input logic [TimeW-1:0] dt);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= dt;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Stop offering, let every due result drain, then let a silent tick finish.
  task automatic wait_quiet();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Writes all four registers back to back; only called while idle.
  task automatic load_settings(input logic [ColorW-1:0] base, input logic [PeriodW-1:0] period,
                               input logic rot, input logic [LenW-1:0] len);
    write_reg(RegBaseColor, base);
    write_reg(RegFramePeriod, CfgDataW'(period));
    write_reg(RegRotateColors, CfgDataW'(rot));
    write_reg(RegStripLength, CfgDataW'(len));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly enough time for a frame within a tick or two, with some quiet ticks.
  function automatic logic [TimeW-1:0] pick_elapsed(input logic [PeriodW-1:0] period);
    case ($urandom_range(9))
      0:       return '0;
      1:       return $urandom;
      2:       return TimeW'(period);
      3:       return TimeW'($urandom_range(15));
      default: return TimeW'(period / 2) + TimeW'($urandom_range(period));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned        mode;
    int unsigned        ph;
    int unsigned        k;
    logic [ColorW-1:0]  base;
    logic [PeriodW-1:0] period;
    logic               rot;
    logic [LenW-1:0]    len;

    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // ---- directed part ----
    load_settings(24'hFFFFFF, 20'd60000, 1'b1, 10'd60);
    send_item(CmdTick, '1);           // frame before any start: clear and show only
    send_item(CmdTick, '0);           // nothing due, no results
    send_item(CmdStart, '1);          // elapsed time ignored; six palette streaks
    send_item(CmdTick, 32'd60000);    // equal to the period is not enough
    send_item(CmdTick, 32'd1);        // now over: frame, streaks still off the strip
    wait_quiet();

    // rotation off, period zero: any nonzero tick renders
    load_settings('1, '0, 1'b0, 10'd80);
    send_item(CmdStart, 32'h5A5A_A5A5);
    send_item(CmdTick, 32'd1);
    wait_quiet();

    // stretch the strip without a restart: all eight streaks land on it, widest frame
    load_settings('0, '1, 1'b0, '1);
    send_item(CmdTick, '1);
    wait_quiet();

    // strip too short for a single streak
    load_settings(24'h00FF00, 20'd100, 1'b1, 10'd9);
    send_item(CmdStart, '0);
    send_item(CmdTick, 32'd101);
    wait_quiet();

    // one streak walked down past the bottom: negative clipping, then wrap and next colour
    load_settings(24'h123456, '0, 1'b1, 10'd10);
    send_item(CmdStart, '0);
    for (k = 0; k < 15; k++) send_item(CmdTick, 32'd1);

    // ---- random part: four idling patterns, three settings each ----
    for (mode = 0; mode < 4; mode++) begin
      for (ph = 0; ph < 3; ph++) begin
        wait_quiet();
        case (mode)
          0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
          1:       begin tx_idle_pct = 55; rx_stall_pct = 0;  end
          2:       begin tx_idle_pct = 0;  rx_stall_pct = 55; end
          default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
        endcase
        case ($urandom_range(3))
          0:       base = '0;
          1:       base = '1;
          default: base = ColorW'($urandom);
        endcase
        case ($urandom_range(7))
          0:       period = '0;
          1:       period = '1;
          2:       period = PeriodW'($urandom);
          default: period = PeriodW'($urandom_range(4000));
        endcase
        rot = 1'($urandom_range(1));
        case ($urandom_range(9))
          0:       len = '0;
          1:       len = '1;
          2:       len = LenW'($urandom_range(1, 9));
          3:       len = LenW'($urandom_range(80, 300));
          default: len = LenW'($urandom_range(10, 40));
        endcase
        load_settings(base, period, rot, len);
        // hold the result side while items keep coming, so the input backs up
        if (mode == 0 && ph == 1) hold_req <= hold_req + 1;
        // usually restart; otherwise old streaks run on under the new settings
        if ($urandom_range(3) != 0) send_item(CmdStart, $urandom);
        for (k = 0; k < PhaseItems; k++) begin
          if ($urandom_range(19) == 0) send_item(CmdStart, $urandom);
          else send_item(CmdTick, pick_elapsed(period));
        end
      end
    end

    wait_quiet();
    $display("Run covered %0d input items and %0d result items in %0d frames (widest %0d).",
             items_sent, results_seen, frames_seen, widest_frame);
    $display("Settings swept extremes and random values under four idling patterns and a hold.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatching result items", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fls_pkg.sv
rtl/fls_div.sv
rtl/fls_ctrl.sv
rtl/fls_dp.sv
rtl/falling_led_streak_animator_core.sv
sim/fls_tb_pkg.sv
sim/streak_frame_checker.sv
sim/tb_falling_led_streak_animator_core.sv
